FILE: src/rwct_pkg.sv
// Package of the ramped weighted choice table: beat types, command codes and constants.
package rwct_pkg;

  // Table geometry and weight format.
  localparam int MAX_LOCATIONS = 16;
  localparam int MAX_SLOTS     = 8;
  localparam int WEIGHT_BITS   = 16;
  localparam int LOC_BITS      = 4;
  localparam int SLOT_BITS     = 3;
  localparam int ADDR_BITS     = LOC_BITS + SLOT_BITS;
  localparam int TABLE_DEPTH   = MAX_LOCATIONS * MAX_SLOTS;

  // Command codes.
  localparam logic [2:0] CMD_SELECT      = 3'd0;
  localparam logic [2:0] CMD_WRITE_CUR   = 3'd1;
  localparam logic [2:0] CMD_WRITE_START = 3'd2;
  localparam logic [2:0] CMD_WRITE_PEAK  = 3'd3;
  localparam logic [2:0] CMD_UPDATE      = 3'd4;

  // Register indexes on the configuration port.
  localparam logic [2:0] REG_PEAK_DELAY  = 3'd0;
  localparam logic [2:0] REG_RAMP_START  = 3'd1;
  localparam logic [2:0] REG_GROWTH      = 3'd2;
  localparam logic [2:0] REG_SLOTS       = 3'd3;
  localparam logic [2:0] REG_LOCATIONS   = 3'd4;

  // Reciprocal of twelve scaled by 2^19, exact for 16-bit dividends.
  localparam logic [15:0] RECIP12 = 16'd43691;
  localparam int RECIP12_SHIFT    = 19;

  // Input beat.
  typedef struct packed {
    logic [2:0]  command;
    logic [3:0]  location;
    logic [2:0]  slot;
    logic [15:0] weight;
    logic [15:0] random_value;
    logic [23:0] now_time;
  } cmd_in_t;

  // Result beat.
  typedef struct packed {
    logic [2:0] chosen_slot;
    logic       fell_through;
  } res_out_t;

endpackage

FILE: src/rwct_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module rwct_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: src/ramped_weighted_choice_table.sv
// Top level of the ramped weighted choice table: command sequencer around three weight RAMs.
//
// Usage: a command beat on in_data is taken at a rising edge with start high and busy low.
// Table writes (current, start, peak) finish in the accepting cycle and keep busy low.
// A select walks the current weights of one location, each slot in a read state and a
// check state on the RAM read port, and raises out_valid for exactly one cycle with the
// chosen slot; busy stays high until that result is raised.
// An update rewrites the current table while busy is high. Growth mode grows slot zero
// of each location and splits the rest over the other slots through the shared bit-serial
// divider (16 quotient bits, one per cycle). Ramp mode writes a clamped entry straight
// from its start or peak weight and divides the others through the same divider.
// The configuration port is APB-style, always ready; registers are to be written only while
// busy is low, which the block does not enforce. Reset (rst_n low, synchronous) returns the
// registers to their defaults and the sequencer to idle; the weight tables hold nothing
// defined until written. Results cannot be held off: out_valid is a single-cycle strobe.
module ramped_weighted_choice_table
  import rwct_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  cmd_in_t     in_data,
  output logic        out_valid,
  output res_out_t    out_data,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // Sequencer states.
  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_SEL_RD  = 4'd1;
  localparam logic [3:0] S_SEL_CHK = 4'd2;
  localparam logic [3:0] S_G_RD    = 4'd3;
  localparam logic [3:0] S_G_MUL   = 4'd4;
  localparam logic [3:0] S_G_RECIP = 4'd5;
  localparam logic [3:0] S_G_SUM   = 4'd6;
  localparam logic [3:0] S_DIV     = 4'd7;
  localparam logic [3:0] S_G_WR    = 4'd8;
  localparam logic [3:0] S_R_RD    = 4'd9;
  localparam logic [3:0] S_R_CHK   = 4'd10;
  localparam logic [3:0] S_R_MUL   = 4'd11;
  localparam logic [3:0] S_R_WR    = 4'd12;

  // Configuration registers.
  logic signed [24:0] pd_r;
  logic [23:0]        ramp_start_r;
  logic [15:0]        growth_r;
  logic [3:0]         slots_r;
  logic [4:0]         locs_r;

  logic cfg_wr;
  assign cfg_wr = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pd_r         <= -25'sd1;
      ramp_start_r <= '0;
      growth_r     <= '0;
      slots_r      <= 4'd8;
      locs_r       <= 5'd16;
    end else if (cfg_wr) begin
      case (paddr[4:2])
        REG_PEAK_DELAY: pd_r         <= $signed(pwdata[24:0]);
        REG_RAMP_START: ramp_start_r <= pwdata[23:0];
        REG_GROWTH:     growth_r     <= pwdata[15:0];
        REG_SLOTS:      slots_r      <= pwdata[3:0];
        REG_LOCATIONS:  locs_r       <= pwdata[4:0];
        default: ;
      endcase
    end
  end

  // Register read-back.
  always_comb begin
    case (paddr[4:2])
      REG_PEAK_DELAY: prdata = {{7{pd_r[24]}}, pd_r};
      REG_RAMP_START: prdata = {8'd0, ramp_start_r};
      REG_GROWTH:     prdata = {16'd0, growth_r};
      REG_SLOTS:      prdata = {28'd0, slots_r};
      REG_LOCATIONS:  prdata = {27'd0, locs_r};
      default:        prdata = '0;
    endcase
  end

  // Effective slot and location counts.
  logic [3:0] n_eff;
  logic [4:0] nl_eff;
  always_comb begin
    if (slots_r < 4'd2) begin
      n_eff = 4'd2;
    end else if (slots_r > 4'(MAX_SLOTS)) begin
      n_eff = 4'(MAX_SLOTS);
    end else begin
      n_eff = slots_r;
    end
    nl_eff = (locs_r > 5'(MAX_LOCATIONS)) ? 5'(MAX_LOCATIONS) : locs_r;
  end

  // Sequencer and datapath registers.
  logic [3:0]  state_r, state_nxt;
  logic        out_valid_r, out_valid_nxt;
  res_out_t    out_data_r, out_data_nxt;
  logic [4:0]  loc_r, loc_nxt;
  logic [3:0]  slot_r, slot_nxt;
  logic [18:0] sum_r, sum_nxt;
  logic [15:0] rv_r, rv_nxt;
  logic        grow_r, grow_nxt;
  logic        fp_r, fp_nxt;
  logic        dpos_r, dpos_nxt;
  logic [23:0] d_r, d_nxt;
  logic [15:0] d0_r, d0_nxt;
  logic [31:0] gp_r, gp_nxt;
  logic [12:0] q12_r, q12_nxt;
  logic [15:0] s_r, s_nxt;
  logic        dir_r, dir_nxt;
  logic [39:0] prod_r, prod_nxt;
  logic [23:0] rem_r, rem_nxt;
  logic [15:0] quo_r, quo_nxt;
  logic [23:0] dvs_r, dvs_nxt;
  logic [4:0]  cnt_r, cnt_nxt;

  // RAM ports.
  logic [ADDR_BITS-1:0]   raddr;
  logic [WEIGHT_BITS-1:0] cur_rdata, start_rdata, peak_rdata;
  logic                   cur_we, start_we, peak_we;
  logic [ADDR_BITS-1:0]   cur_waddr, in_addr;
  logic [WEIGHT_BITS-1:0] cur_wdata;

  logic accept;
  assign busy    = (state_r != S_IDLE);
  assign accept  = start && !busy;
  assign raddr   = {loc_r[3:0], slot_r[2:0]};
  assign in_addr = {in_data.location, in_data.slot};
  assign start_we = accept && (in_data.command == CMD_WRITE_START);
  assign peak_we  = accept && (in_data.command == CMD_WRITE_PEAK);

  rwct_ram #(.WIDTH(WEIGHT_BITS), .DEPTH(TABLE_DEPTH)) u_cur_ram (
    .clk(clk), .we(cur_we), .waddr(cur_waddr), .wdata(cur_wdata),
    .raddr(raddr), .rdata(cur_rdata)
  );
  rwct_ram #(.WIDTH(WEIGHT_BITS), .DEPTH(TABLE_DEPTH)) u_start_ram (
    .clk(clk), .we(start_we), .waddr(in_addr), .wdata(in_data.weight),
    .raddr(raddr), .rdata(start_rdata)
  );
  rwct_ram #(.WIDTH(WEIGHT_BITS), .DEPTH(TABLE_DEPTH)) u_peak_ram (
    .clk(clk), .we(peak_we), .waddr(in_addr), .wdata(in_data.weight),
    .raddr(raddr), .rdata(peak_rdata)
  );

  // Time offset into the ramp, as a signed value.
  logic signed [24:0] d_full;
  assign d_full = $signed({1'b0, in_data.now_time} - {1'b0, ramp_start_r});

  // One restoring division step.
  logic [24:0] rem2, rem_sub;
  logic        div_ge;
  assign rem2    = {rem_r, quo_r[15]};
  assign div_ge  = rem2 >= {1'b0, dvs_r};
  assign rem_sub = rem2 - {1'b0, dvs_r};

  // Running sum for select.
  logic [18:0] sum_add;
  assign sum_add = sum_r + 19'(cur_rdata);

  // Growth arithmetic.
  logic [31:0] recip_prod;
  logic [16:0] grow_sum, grow_rest;
  logic [15:0] grow_new;
  assign recip_prod = 32'(gp_r[31:16]) * 32'(RECIP12);
  assign grow_sum   = {1'b0, d0_r} + 17'(q12_r);
  assign grow_new   = grow_sum[16] ? 16'hFFFF : grow_sum[15:0];
  assign grow_rest  = 17'h10000 - {1'b0, grow_new};

  // Ramp magnitude.
  logic        ramp_up;
  logic [15:0] ramp_mag;
  assign ramp_up  = peak_rdata >= start_rdata;
  assign ramp_mag = ramp_up ? (peak_rdata - start_rdata) : (start_rdata - peak_rdata);

  logic last_slot, last_loc;
  assign last_slot = (slot_r == n_eff - 4'd1);
  assign last_loc  = (loc_r == nl_eff - 5'd1);

  // Next-state logic of the sequencer.
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = 1'b0;
    out_data_nxt  = out_data_r;
    loc_nxt       = loc_r;
    slot_nxt      = slot_r;
    sum_nxt       = sum_r;
    rv_nxt        = rv_r;
    grow_nxt      = grow_r;
    fp_nxt        = fp_r;
    dpos_nxt      = dpos_r;
    d_nxt         = d_r;
    d0_nxt        = d0_r;
    gp_nxt        = gp_r;
    q12_nxt       = q12_r;
    s_nxt         = s_r;
    dir_nxt       = dir_r;
    prod_nxt      = prod_r;
    rem_nxt       = rem_r;
    quo_nxt       = quo_r;
    dvs_nxt       = dvs_r;
    cnt_nxt       = cnt_r;
    cur_we        = 1'b0;
    cur_waddr     = raddr;
    cur_wdata     = in_data.weight;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (in_data.command)
            CMD_SELECT: begin
              loc_nxt   = {1'b0, in_data.location};
              slot_nxt  = '0;
              sum_nxt   = '0;
              rv_nxt    = in_data.random_value;
              state_nxt = S_SEL_RD;
            end
            CMD_WRITE_CUR: begin
              cur_we    = 1'b1;
              cur_waddr = in_addr;
            end
            CMD_UPDATE: begin
              loc_nxt  = '0;
              slot_nxt = '0;
              grow_nxt = (pd_r == -25'sd1);
              fp_nxt   = (pd_r <= 25'sd0) || (d_full > pd_r);
              dpos_nxt = (d_full > 25'sd0);
              d_nxt    = d_full[23:0];
              if (nl_eff != 5'd0) begin
                state_nxt = (pd_r == -25'sd1) ? S_G_RD : S_R_RD;
              end
            end
            default: ;
          endcase
        end
      end

      // Select: one slot per read.
      S_SEL_RD: state_nxt = S_SEL_CHK;
      S_SEL_CHK: begin
        sum_nxt = sum_add;
        if ({3'd0, rv_r} <= sum_add) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = '{chosen_slot: slot_r[2:0], fell_through: 1'b0};
          state_nxt     = S_IDLE;
        end else if (last_slot) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = '{chosen_slot: slot_r[2:0], fell_through: 1'b1};
          state_nxt     = S_IDLE;
        end else begin
          slot_nxt  = slot_r + 4'd1;
          state_nxt = S_SEL_RD;
        end
      end

      // Growth: slot zero grows, the rest share what is left.
      S_G_RD: state_nxt = S_G_MUL;
      S_G_MUL: begin
        d0_nxt    = cur_rdata;
        gp_nxt    = 32'(cur_rdata) * 32'(growth_r);
        state_nxt = S_G_RECIP;
      end
      S_G_RECIP: begin
        q12_nxt   = recip_prod[31:RECIP12_SHIFT];
        state_nxt = S_G_SUM;
      end
      S_G_SUM: begin
        cur_we    = 1'b1;
        cur_wdata = grow_new;
        slot_nxt  = 4'd1;
        if (grow_new == 16'd0 && n_eff == 4'd2) begin
          // The whole unit over one slot saturates to the largest weight.
          quo_nxt   = 16'hFFFF;
          state_nxt = S_G_WR;
        end else begin
          rem_nxt   = 24'(grow_rest[16]);
          quo_nxt   = grow_rest[15:0];
          dvs_nxt   = 24'(n_eff - 4'd1);
          cnt_nxt   = 5'd16;
          state_nxt = S_DIV;
        end
      end
      S_G_WR: begin
        cur_we    = 1'b1;
        cur_wdata = quo_r;
        if (last_slot) begin
          slot_nxt = '0;
          loc_nxt  = loc_r + 5'd1;
          state_nxt = last_loc ? S_IDLE : S_G_RD;
        end else begin
          slot_nxt = slot_r + 4'd1;
        end
      end

      // Shared bit-serial divider, one quotient bit a cycle.
      S_DIV: begin
        if (cnt_r == 5'd0) begin
          state_nxt = grow_r ? S_G_WR : S_R_WR;
        end else begin
          rem_nxt = div_ge ? rem_sub[23:0] : rem2[23:0];
          quo_nxt = {quo_r[14:0], div_ge};
          cnt_nxt = cnt_r - 5'd1;
        end
      end

      // Ramp: interpolate each entry from start toward peak.
      S_R_RD: state_nxt = S_R_CHK;
      S_R_CHK: begin
        if (fp_r || !dpos_r) begin
          cur_we    = 1'b1;
          cur_wdata = fp_r ? peak_rdata : start_rdata;
          if (last_slot) begin
            slot_nxt = '0;
            loc_nxt  = loc_r + 5'd1;
            state_nxt = last_loc ? S_IDLE : S_R_RD;
          end else begin
            slot_nxt  = slot_r + 4'd1;
            state_nxt = S_R_RD;
          end
        end else begin
          s_nxt     = start_rdata;
          dir_nxt   = ramp_up;
          prod_nxt  = 40'(ramp_mag) * 40'(d_r);
          state_nxt = S_R_MUL;
        end
      end
      S_R_MUL: begin
        rem_nxt   = prod_r[39:16];
        quo_nxt   = prod_r[15:0];
        dvs_nxt   = pd_r[23:0];
        cnt_nxt   = 5'd16;
        state_nxt = S_DIV;
      end
      S_R_WR: begin
        cur_we    = 1'b1;
        cur_wdata = dir_r ? (s_r + quo_r) : (s_r - quo_r);
        if (last_slot) begin
          slot_nxt = '0;
          loc_nxt  = loc_r + 5'd1;
          state_nxt = last_loc ? S_IDLE : S_R_RD;
        end else begin
          slot_nxt  = slot_r + 4'd1;
          state_nxt = S_R_RD;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    loc_r      <= loc_nxt;
    slot_r     <= slot_nxt;
    sum_r      <= sum_nxt;
    rv_r       <= rv_nxt;
    grow_r     <= grow_nxt;
    fp_r       <= fp_nxt;
    dpos_r     <= dpos_nxt;
    d_r        <= d_nxt;
    d0_r       <= d0_nxt;
    gp_r       <= gp_nxt;
    q12_r      <= q12_nxt;
    s_r        <= s_nxt;
    dir_r      <= dir_nxt;
    prod_r     <= prod_nxt;
    rem_r      <= rem_nxt;
    quo_r      <= quo_nxt;
    dvs_r      <= dvs_nxt;
    cnt_r      <= cnt_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // A result strobe lasts one cycle and arrives with the sequencer back at idle.
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |=> !out_valid_r) else $error("result strobe held");
  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !busy) else $error("result while busy");
  // The divider remainder stays below the divisor.
  a_div_rem: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |-> (rem_r < dvs_r)) else $error("divider remainder overflow");
  // Growth never rewrites slot zero with the shared share.
  a_grow_slot: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_G_WR) |-> (slot_r != 4'd0)) else $error("growth share on slot zero");

endmodule

FILE: tb/tb_top.sv
// Self-checking testbench for the ramped weighted choice table.
module tb_top
  import rwct_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  // Register index that the block does not implement.
  localparam logic [2:0] REG_UNUSED = 3'd7;
  // Command codes that the block ignores.
  localparam logic [2:0] CMD_SPARE_A = 3'd5;
  localparam logic [2:0] CMD_SPARE_B = 3'd6;
  localparam logic [2:0] CMD_SPARE_C = 3'd7;
  localparam int         ITEMS_PER_PHASE = 135;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  cmd_in_t     in_data = '0;
  logic        out_valid;
  res_out_t    out_data;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  ramped_weighted_choice_table dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_data(in_data),
    .out_valid(out_valid), .out_data(out_data), .psel(psel), .penable(penable),
    .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #1 clk = ~clk;

  // Shadow copy of the weight tables and registers.
  logic [15:0]        cur_w [TABLE_DEPTH];
  logic [15:0]        start_w [TABLE_DEPTH];
  logic [15:0]        peak_w [TABLE_DEPTH];
  logic signed [24:0] ramp_len;
  logic [23:0]        ramp_origin;
  logic [15:0]        growth_rate;
  logic [3:0]         slot_count;
  logic [4:0]         loc_count;

  res_out_t pending_choices[$];
  int       errors = 0;
  int       n_selects = 0, n_fallthrough = 0, n_updates = 0, n_beats = 0;
  int       idle_pct = 0;

  function automatic cmd_in_t beat(logic [2:0] c, logic [3:0] l, logic [2:0] s,
                                   logic [15:0] w, logic [15:0] rv, logic [23:0] t);
    cmd_in_t b;
    b.command = c; b.location = l; b.slot = s; b.weight = w;
    b.random_value = rv; b.now_time = t;
    return b;
  endfunction

  // Clamped slot count used by selects and updates.
  function automatic int live_slots();
    if (slot_count < 2) return 2;
    if (slot_count > MAX_SLOTS) return MAX_SLOTS;
    return slot_count;
  endfunction

  // One entry of the linear ramp from start toward peak.
  function automatic logic [15:0] ramp_weight(longint s, longint p, longint d, longint len);
    longint mag, step;
    if (d <= 0) return s[15:0];
    mag = (p >= s) ? p - s : s - p;
    step = (mag * d) / len;
    if (step > mag) step = mag;
    return (p >= s) ? 16'(s + step) : 16'(s - step);
  endfunction

  // Update command: monthly growth of slot zero, or the ramp toward peak.
  task automatic rewrite_current(logic [23:0] now);
    int     nl, ns, base;
    longint d0, d, other, dt;
    nl = (loc_count > MAX_LOCATIONS) ? MAX_LOCATIONS : loc_count;
    ns = live_slots();
    dt = longint'(now) - longint'(ramp_origin);
    for (int loc = 0; loc < nl; loc++) begin
      base = loc * MAX_SLOTS;
      if (ramp_len == -1) begin
        d0 = cur_w[base];
        d = d0 + (d0 * growth_rate) / (12 * 65536);
        if (d > 65535) d = 65535;
        cur_w[base] = d[15:0];
        other = (65536 - d) / (ns - 1);
        if (other > 65535) other = 65535;
        for (int i = 1; i < ns; i++) cur_w[base + i] = other[15:0];
      end else begin
        for (int i = 0; i < ns; i++) begin
          if (ramp_len <= 0 || dt > longint'(ramp_len)) cur_w[base + i] = peak_w[base + i];
          else cur_w[base + i] = ramp_weight(start_w[base + i], peak_w[base + i], dt,
                                             longint'(ramp_len));
        end
      end
    end
  endtask

  // Applies one accepted beat to the shadow state; a select yields a choice.
  task automatic predict_choice(cmd_in_t b, output bit has_choice, output res_out_t choice);
    int     base, ns;
    longint sum;
    base = b.location * MAX_SLOTS;
    has_choice = 1'b0;
    choice = '0;
    case (b.command)
      CMD_SELECT: begin
        ns = live_slots();
        sum = 0;
        has_choice = 1'b1;
        choice.chosen_slot = 3'(ns - 1);
        choice.fell_through = 1'b1;
        for (int i = 0; i < ns; i++) begin
          sum += cur_w[base + i];
          if (b.random_value <= sum) begin
            choice.chosen_slot = 3'(i);
            choice.fell_through = 1'b0;
            break;
          end
        end
      end
      CMD_WRITE_CUR:   cur_w[base + b.slot] = b.weight;
      CMD_WRITE_START: start_w[base + b.slot] = b.weight;
      CMD_WRITE_PEAK:  peak_w[base + b.slot] = b.weight;
      CMD_UPDATE:      rewrite_current(b.now_time);
      default: ;
    endcase
  endtask

  // Drives one beat, holds it until taken, then records what it should cause.
  task automatic send(cmd_in_t b, bit typed = 1'b0, res_out_t typed_choice = '0);
    bit       has;
    res_out_t r;
    int       gap;
    gap = ($urandom_range(99) < idle_pct) ? $urandom_range(1, 6) : 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_data <= b;
    do @(posedge clk); while (busy);
    predict_choice(b, has, r);
    n_beats++;
    if (b.command == CMD_UPDATE) n_updates++;
    if (has) begin
      n_selects++;
      if (r.fell_through) n_fallthrough++;
      pending_choices.insert(pending_choices.size(), typed ? typed_choice : r);
    end
  endtask

  // Lowers start and waits until the block has drained and gone quiet.
  task automatic drain();
    start <= 1'b0;
    do @(posedge clk); while (pending_choices.size() != 0 || busy);
    repeat (4) @(posedge clk);
  endtask

  // Register write on the configuration port: a setup phase, then an access phase.
  task automatic write_reg(logic [2:0] idx, logic [31:0] value);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {idx, 2'b00}; pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      REG_PEAK_DELAY: ramp_len = value[24:0];
      REG_RAMP_START: ramp_origin = value[23:0];
      REG_GROWTH:     growth_rate = value[15:0];
      REG_SLOTS:      slot_count = value[3:0];
      REG_LOCATIONS:  loc_count = value[4:0];
      default: ;
    endcase
  endtask

  task automatic configure(int pd, int rs, int g, int sl, int lc);
    write_reg(REG_PEAK_DELAY, 32'(pd));
    write_reg(REG_RAMP_START, 32'(rs));
    write_reg(REG_GROWTH, 32'(g));
    write_reg(REG_SLOTS, 32'(sl));
    write_reg(REG_LOCATIONS, 32'(lc));
  endtask

  function automatic logic [15:0] rand_weight();
    case ($urandom_range(5))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return 16'($urandom_range(0, 4095));
      3: return 16'($urandom_range(0, 16383));
      default: return 16'($urandom);
    endcase
  endfunction

  // Times around the ramp window in half of the draws, otherwise at either extreme or anywhere.
  function automatic logic [23:0] rand_time();
    longint span;
    span = (ramp_len > 0) ? longint'(ramp_len) : 64;
    case ($urandom_range(5))
      0: return 24'h000000;
      1: return 24'hFFFFFF;
      2: return 24'($urandom);
      default: return 24'(longint'(ramp_origin) - 8 + longint'($urandom_range(0, 32'(span * 2))));
    endcase
  endfunction

  function automatic cmd_in_t rand_beat();
    int       pick;
    logic [2:0] c;
    pick = $urandom_range(99);
    if (pick < 50)      c = CMD_SELECT;
    else if (pick < 65) c = CMD_WRITE_CUR;
    else if (pick < 77) c = CMD_WRITE_START;
    else if (pick < 89) c = CMD_WRITE_PEAK;
    else if (pick < 95) c = CMD_UPDATE;
    else                c = 3'($urandom_range(int'(CMD_SPARE_A), int'(CMD_SPARE_C)));
    return beat(c, 4'($urandom), 3'($urandom), rand_weight(), 16'($urandom), rand_time());
  endfunction

  // Result checker: every strobe must match the oldest outstanding choice.
  always @(posedge clk) begin
    res_out_t want;
    if (rst_n && out_valid) begin
      if (pending_choices.size() == 0) begin
        errors++;
        $display("%0t: unexpected result slot=%0d fell=%0b", $time,
                 out_data.chosen_slot, out_data.fell_through);
      end else begin
        want = pending_choices.pop_front();
        if (out_data.chosen_slot !== want.chosen_slot) begin
          errors++;
          $display("%0t: chosen_slot expected %0d got %0d", $time,
                   want.chosen_slot, out_data.chosen_slot);
        end
        if (out_data.fell_through !== want.fell_through) begin
          errors++;
          $display("%0t: fell_through expected %0b got %0b", $time,
                   want.fell_through, out_data.fell_through);
        end
      end
    end
  end

  // Stimulus and end of run.
  initial begin
    cmd_in_t   dir_beats[$];
    bit        dir_typed[$];
    res_out_t  dir_want[$];
    int        phase_cfg[6][5];

    ramp_len = -1; ramp_origin = '0; growth_rate = '0; slot_count = 4'd8; loc_count = 5'd16;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Load every table entry so that no read ever meets an unwritten one.
    for (int loc = 0; loc < MAX_LOCATIONS; loc++)
      for (int s = 0; s < MAX_SLOTS; s++) begin
        send(beat(CMD_WRITE_CUR, 4'(loc), 3'(s), rand_weight(), '0, '0));
        send(beat(CMD_WRITE_START, 4'(loc), 3'(s), rand_weight(), '0, '0));
        send(beat(CMD_WRITE_PEAK, 4'(loc), 3'(s), rand_weight(), '0, '0));
      end

    // Directed beats: extremes, every command and the unknown codes.
    dir_beats = '{beat(CMD_WRITE_CUR, 4'd15, 3'd0, 16'h0000, '0, '0),
                  beat(CMD_WRITE_CUR, 4'd15, 3'd1, 16'hFFFF, '0, '0),
                  beat(CMD_SELECT, 4'd15, 3'd0, '0, 16'h0000, '0),
                  beat(CMD_SELECT, 4'd15, 3'd0, '0, 16'hFFFF, '0),
                  beat(CMD_SELECT, 4'd0, 3'd7, '0, 16'hFFFF, '0),
                  beat(CMD_SELECT, 4'd7, 3'd0, '0, 16'h0001, '0),
                  beat(CMD_SPARE_A, 4'd15, 3'd1, 16'h0000, '0, '0),
                  beat(CMD_SPARE_B, 4'd15, 3'd1, 16'h1234, '0, '0),
                  beat(CMD_SPARE_C, 4'd15, 3'd0, 16'h0000, 16'hFFFF, 24'hFFFFFF),
                  beat(CMD_SELECT, 4'd15, 3'd0, '0, 16'hFFFF, '0),
                  beat(CMD_WRITE_START, 4'd15, 3'd7, 16'hFFFF, '0, '0),
                  beat(CMD_WRITE_PEAK, 4'd15, 3'd7, 16'h0000, '0, '0),
                  beat(CMD_WRITE_CUR, 4'd3, 3'd0, 16'h0001, '0, '0),
                  beat(CMD_UPDATE, 4'd0, 3'd0, '0, '0, 24'hFFFFFF),
                  beat(CMD_SELECT, 4'd15, 3'd0, '0, 16'hFFFF, '0),
                  beat(CMD_SELECT, 4'd3, 3'd0, '0, 16'h0001, '0),
                  beat(CMD_SELECT, 4'd3, 3'd0, '0, 16'h8000, '0)};
    dir_typed = '{0, 0, 1, 1, 0, 0, 0, 0, 0, 1, 0, 0, 0, 0, 0, 1, 0};
    dir_want  = '{'0, '0, res_out_t'{3'd0, 1'b0}, res_out_t'{3'd1, 1'b0}, '0, '0, '0, '0, '0,
                  res_out_t'{3'd1, 1'b0}, '0, '0, '0, '0, '0, res_out_t'{3'd0, 1'b0}, '0};
    foreach (dir_beats[i]) send(dir_beats[i], dir_typed[i], dir_want[i]);
    drain();

    // Register settings per phase: ramp length, ramp start, growth, slots, locations.
    phase_cfg = '{'{-1, 0, 65535, 8, 16},
                  '{1000, 500, 0, 2, 3},
                  '{16777215, 16777215, 12345, 0, 31},
                  '{-16777216, 0, 0, 15, 1},
                  '{0, 123, 0, 1, 0},
                  '{64, 8000000, 30000, 5, 7}};
    for (int p = 0; p < 6; p++) begin
      configure(phase_cfg[p][0], phase_cfg[p][1], phase_cfg[p][2], phase_cfg[p][3],
                phase_cfg[p][4]);
      if (p == 3) write_reg(REG_UNUSED, 32'hFFFFFFFF);
      for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
        case ((k / 34) % 4)
          0: idle_pct = 0;
          1: idle_pct = 46;
          2: idle_pct = 0;
          default: idle_pct = 18;
        endcase
        send(rand_beat());
      end
      drain();
    end

    start <= 1'b0;
    repeat (50) @(posedge clk);
    $display("Covered %0d beats: %0d selects (%0d fell through), %0d table updates,",
             n_beats, n_selects, n_fallthrough, n_updates);
    $display("across growth, ramp, clamped and empty settings with and without idle gaps.");
    if (errors == 0 && pending_choices.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d mismatches, %0d results missing", errors, pending_choices.size());
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Watchdog for a block that stops responding.
  initial begin
    #40_000_000;
    $display("Timed out waiting for the block");
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
